// File: rtl/feedback_sample_collector_macros.svh
// ----------------------------------------------------------------------------
// feedback sample collector assertion macros
// shared concurrent check forms, clocked on aclk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_SAMPLE_COLLECTOR_MACROS_SVH
`define FEEDBACK_SAMPLE_COLLECTOR_MACROS_SVH

// condition must hold at every clock edge out of reset
`define FSC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define FSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/fsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg
// types and codes shared by the feedback sample collector
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int ADDR_W      = 64;
    localparam int CAP_W       = 7;
    localparam int CNT_W       = 7;
    localparam int TOT_W       = 32;
    localparam int DEF_DEPTH   = 64;

    // input opcodes
    localparam logic [1:0] OP_RECORD  = 2'd0;
    localparam logic [1:0] OP_SWAP    = 2'd1;
    localparam logic [1:0] OP_RESOLVE = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_RECORD  = 2'd0;
    localparam logic [1:0] KIND_SWAP    = 2'd1;
    localparam logic [1:0] KIND_RESOLVE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // sample traveling down the cell row
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } travel_t;

    // distinct entry held by one cell
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } entry_t;

    // row control from the sequencer
    typedef struct packed {
        logic clear;
        logic shift;
    } chain_ctl_t;

endpackage

// File: rtl/fsc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_cell
// one dedup cell: captures a new address, counts repeats, passes others on
// ----------------------------------------------------------------------------
module fsc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  fsc_pkg::chain_ctl_t ctl,
    input  fsc_pkg::travel_t    travel_in,
    input  fsc_pkg::entry_t     right_entry,
    output fsc_pkg::travel_t    travel_out,
    output fsc_pkg::entry_t     entry
);
    import fsc_pkg::*;

    travel_t travel_reg, travel_next;
    entry_t  entry_reg, entry_next;

    // clear, shift, capture, count or forward
    always_comb begin
        travel_next       = '0;
        entry_next        = entry_reg;
        if (ctl.clear) begin
            entry_next = '0;
        end else if (ctl.shift) begin
            entry_next = right_entry;
        end else if (travel_in.valid) begin
            if (!entry_reg.valid) begin
                entry_next.valid = 1'b1;
                entry_next.addr  = travel_in.addr;
                entry_next.count = CNT_W'(1);
            end else if (entry_reg.addr == travel_in.addr) begin
                entry_next.count = entry_reg.count + CNT_W'(1);
            end else begin
                travel_next = travel_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            travel_reg <= '0;
            entry_reg  <= '0;
        end else begin
            travel_reg <= travel_next;
            entry_reg  <= entry_next;
        end
    end

    assign travel_out = travel_reg;
    assign entry      = entry_reg;

endmodule

// File: rtl/fsc_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_chain
// row of dedup cells; samples enter at the head, entries shift out at the head
// ----------------------------------------------------------------------------
module fsc_chain #(
    parameter int BANK_DEPTH = fsc_pkg::DEF_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fsc_pkg::chain_ctl_t ctl,
    input  fsc_pkg::travel_t    sample_in,
    output fsc_pkg::entry_t     head_entry,
    output logic                second_valid
);
    import fsc_pkg::*;

    travel_t travel [0:BANK_DEPTH];
    entry_t  entries [0:BANK_DEPTH];

    assign travel[0]           = sample_in;
    assign entries[BANK_DEPTH] = '0;

    // cell row
    for (genvar i = 0; i < BANK_DEPTH; i++) begin : g_cell
        fsc_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .travel_in   (travel[i]),
            .right_entry (entries[i+1]),
            .travel_out  (travel[i+1]),
            .entry       (entries[i])
        );
    end

    assign head_entry   = entries[0];
    assign second_valid = entries[1].valid;

endmodule

// File: rtl/feedback_sample_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_sample_collector
// double-banked page address collector with distinct-address resolve
// ----------------------------------------------------------------------------
// Record and swap requests are answered with one result each. A resolve of
// a bank holding n samples reads the sample memory one entry per cycle,
// lets the samples pass the dedup cell row, then emits one result per
// distinct address, one per cycle while the consumer takes them; an empty
// bank answers at once with one result of count 0. One request is in work
// at a time. Writing capacity clears fills, bank selection and totals; it
// is taken only when the block is idle with no result pending, and holds
// off requests meanwhile.
module feedback_sample_collector #(
    parameter int BANK_DEPTH = fsc_pkg::DEF_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration: capacity
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fsc_pkg::CAP_W-1:0]  cfg_data,
    // requests
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,  // page_address
    input  logic [1:0]                 s_axis_tuser,  // opcode
    // results
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // accepted, unique_address, sample_count, recorded_total,
    // dropped_total, swap_total
    output logic [167:0]               m_axis_tdata,
    output logic [1:0]                 m_axis_tuser,  // result_kind
    output logic                       m_axis_tlast   // last_entry
);
    import fsc_pkg::*;

    `include "feedback_sample_collector_macros.svh"

    localparam int IDX_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int MA_W  = IDX_W + 1;
    localparam int MEM_D = 2 * BANK_DEPTH;

    state_t                state_reg, state_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      fill_reg [2];
    logic                  active_reg, retired_reg;
    logic [TOT_W-1:0]      rec_reg, drop_reg, swap_reg;
    logic [CNT_W-1:0]      n_reg, idx_reg, drain_reg;
    logic [ADDR_W-1:0]     mem [MEM_D];
    logic [ADDR_W-1:0]     rd_data_reg;
    logic                  rd_vld_reg;
    logic                  out_valid_reg, out_acc_reg, out_last_reg;
    logic [1:0]            out_kind_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [CNT_W-1:0]      out_cnt_reg;

    logic                  in_fire, cfg_fire, out_free;
    logic [CAP_W-1:0]      eff_cap;
    logic [CNT_W-1:0]      act_fill, ret_fill;
    logic                  rec_ok;
    logic [MA_W-1:0]       wr_addr, rd_addr;
    logic                  emit_go;
    chain_ctl_t            ctl;
    travel_t               sample_in;
    entry_t                head_entry;
    logic                  second_valid;

    assign cfg_ready     = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free && !cfg_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign eff_cap       = (cap_reg > CAP_W'(BANK_DEPTH)) ? CAP_W'(BANK_DEPTH) : cap_reg;
    assign act_fill      = fill_reg[active_reg];
    assign ret_fill      = fill_reg[retired_reg];
    assign rec_ok        = act_fill < eff_cap;
    assign wr_addr       = (active_reg ? MA_W'(BANK_DEPTH) : MA_W'(0))
                           + MA_W'(act_fill[IDX_W-1:0]);
    assign rd_addr       = (retired_reg ? MA_W'(BANK_DEPTH) : MA_W'(0))
                           + MA_W'(idx_reg[IDX_W-1:0]);
    assign emit_go       = (state_reg == ST_EMIT) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_axis_tuser == OP_RESOLVE && ret_fill != '0) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (idx_reg + CNT_W'(1) == n_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg == CNT_W'(BANK_DEPTH + 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_go && !second_valid) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // row control
    always_comb begin
        ctl.clear = in_fire && (s_axis_tuser == OP_RESOLVE);
        ctl.shift = emit_go;
    end

    assign sample_in.valid = rd_vld_reg;
    assign sample_in.addr  = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // bank state and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= '0;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            active_reg  <= 1'b0;
            retired_reg <= 1'b1;
            rec_reg     <= '0;
            drop_reg    <= '0;
            swap_reg    <= '0;
        end else if (cfg_fire) begin
            cap_reg     <= cfg_data;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            active_reg  <= 1'b0;
            retired_reg <= 1'b1;
            rec_reg     <= '0;
            drop_reg    <= '0;
            swap_reg    <= '0;
        end else if (in_fire) begin
            if (s_axis_tuser == OP_RECORD) begin
                if (rec_ok) begin
                    fill_reg[active_reg] <= act_fill + CNT_W'(1);
                    rec_reg              <= rec_reg + TOT_W'(1);
                end else begin
                    drop_reg <= drop_reg + TOT_W'(1);
                end
            end else if (s_axis_tuser == OP_SWAP) begin
                fill_reg[!active_reg] <= '0;
                active_reg            <= !active_reg;
                retired_reg           <= active_reg;
                swap_reg              <= swap_reg + TOT_W'(1);
            end
        end
    end

    // sample memory
    always_ff @(posedge aclk) begin
        if (in_fire && s_axis_tuser == OP_RECORD && rec_ok) begin
            mem[wr_addr] <= s_axis_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // read walk and drain counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            idx_reg    <= '0;
            drain_reg  <= '0;
            n_reg      <= '0;
        end else begin
            rd_vld_reg <= (state_reg == ST_READ);
            if (state_reg == ST_IDLE) begin
                idx_reg   <= '0;
                drain_reg <= '0;
                n_reg     <= ret_fill;
            end else if (state_reg == ST_READ) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end else if (state_reg == ST_DRAIN) begin
                drain_reg <= drain_reg + CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire && s_axis_tuser != OP_NONE
                     && !(s_axis_tuser == OP_RESOLVE && ret_fill != '0)) begin
            out_valid_reg <= 1'b1;
        end else if (emit_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_kind_reg <= s_axis_tuser;
            out_acc_reg  <= (s_axis_tuser == OP_RECORD) && rec_ok;
            out_addr_reg <= '0;
            out_cnt_reg  <= '0;
            out_last_reg <= 1'b1;
        end else if (emit_go) begin
            out_kind_reg <= KIND_RESOLVE;
            out_acc_reg  <= 1'b0;
            out_addr_reg <= head_entry.addr;
            out_cnt_reg  <= head_entry.count;
            out_last_reg <= !second_valid;
        end
    end

    fsc_chain #(
        .BANK_DEPTH (BANK_DEPTH)
    ) u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .sample_in    (sample_in),
        .head_entry   (head_entry),
        .second_valid (second_valid)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {swap_reg, drop_reg, rec_reg, out_cnt_reg, out_addr_reg, out_acc_reg};

    // checks
    `FSC_ASSERT_IMPL(a_ready_idle, s_axis_tready, state_reg == ST_IDLE, "ready while busy")
    `FSC_ASSERT_ALWAYS(a_fill0_bound, fill_reg[0] <= CNT_W'(BANK_DEPTH), "fill beyond depth")
    `FSC_ASSERT_ALWAYS(a_fill1_bound, fill_reg[1] <= CNT_W'(BANK_DEPTH), "fill beyond depth")
    `FSC_ASSERT_IMPL(a_emit_head, state_reg == ST_EMIT, head_entry.valid, "emit with empty head")
    `FSC_ASSERT_IMPL(a_zero_last, out_valid_reg && out_cnt_reg == '0, out_last_reg, "bad last")

endmodule

// File: sim/tb_feedback_sample_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feedback_sample_collector
// self-checking bench: record, swap and resolve requests against a predictor
// of the two sample banks and their distinct-address walk
// ----------------------------------------------------------------------------
module tb_feedback_sample_collector;
    import fsc_pkg::*;

    localparam int DEPTH    = 64;
    localparam int LIMIT    = 400000;
    localparam int SETTLE   = 2 * DEPTH + 20;

    typedef struct packed {
        logic [1:0]        kind;
        logic              accepted;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic [TOT_W-1:0]  stored;
        logic [TOT_W-1:0]  dropped;
        logic [TOT_W-1:0]  swaps;
    } answer_t;

    // predictor of the collector and queue of answers still owed
    class collector_scoreboard;
        logic [ADDR_W-1:0] bank_mem [2][DEPTH];
        int unsigned       fill [2];
        bit                active;
        bit                retired;
        logic [TOT_W-1:0]  stored_tot, dropped_tot, swap_tot;
        int unsigned       cap;
        answer_t           owed [$];
        int                mismatches;
        int                checked;

        function void clear_all(int unsigned new_cap);
            fill[0] = 0;
            fill[1] = 0;
            active = 0;
            retired = 1;
            stored_tot = 0;
            dropped_tot = 0;
            swap_tot = 0;
            cap = (new_cap > DEPTH) ? DEPTH : new_cap;
        endfunction

        function answer_t make(logic [1:0] k, logic acc, logic [ADDR_W-1:0] a,
                               logic [CNT_W-1:0] c, logic l);
            answer_t r;
            r.kind = k;
            r.accepted = acc;
            r.addr = a;
            r.count = c;
            r.last = l;
            r.stored = stored_tot;
            r.dropped = dropped_tot;
            r.swaps = swap_tot;
            return r;
        endfunction

        // append one answer to the owed queue
        function void owe(answer_t r);
            owed.insert(owed.size(), r);
        endfunction

        function void note_request(logic [1:0] op, logic [ADDR_W-1:0] a);
            logic [ADDR_W-1:0] uaddr [$];
            int unsigned       ucnt [$];
            int unsigned       n;
            bit                hit;
            if (op == OP_RECORD) begin
                if (fill[active] < cap) begin
                    bank_mem[active][fill[active]] = a;
                    fill[active]++;
                    stored_tot++;
                    owe(make(KIND_RECORD, 1'b1, '0, '0, 1'b1));
                end else begin
                    dropped_tot++;
                    owe(make(KIND_RECORD, 1'b0, '0, '0, 1'b1));
                end
            end else if (op == OP_SWAP) begin
                fill[!active] = 0;
                retired = active;
                active = !active;
                swap_tot++;
                owe(make(KIND_SWAP, 1'b0, '0, '0, 1'b1));
            end else if (op == OP_RESOLVE) begin
                n = (fill[retired] > cap) ? cap : fill[retired];
                if (n == 0) begin
                    owe(make(KIND_RESOLVE, 1'b0, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        hit = 0;
                        for (int j = 0; j < uaddr.size(); j++) begin
                            if (!hit && uaddr[j] == bank_mem[retired][i]) begin
                                ucnt[j]++;
                                hit = 1;
                            end
                        end
                        if (!hit) begin
                            uaddr.insert(uaddr.size(), bank_mem[retired][i]);
                            ucnt.insert(ucnt.size(), 1);
                        end
                    end
                    foreach (uaddr[j])
                        owe(make(KIND_RESOLVE, 1'b0, uaddr[j],
                                 CNT_W'(ucnt[j]), j == uaddr.size() - 1));
                end
            end
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            checked++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          cfg_valid = 0;
    logic          cfg_ready;
    logic [6:0]    cfg_data = '0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [63:0]   s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [167:0]  m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tlast;

    collector_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    int  cycle_count = 0;
    int  req_count = 0;

    feedback_sample_collector #(.BANK_DEPTH(DEPTH)) DUT (.*);

    // clock, 8 ns period
    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls and a long hold-off on request
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result sampling: tdata low to high is accepted, address, count, totals
    always @(posedge aclk) begin
        answer_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.accepted = m_axis_tdata[0];
            got.addr = m_axis_tdata[64:1];
            got.count = m_axis_tdata[71:65];
            got.last = m_axis_tlast;
            got.stored = m_axis_tdata[103:72];
            got.dropped = m_axis_tdata[135:104];
            got.swaps = m_axis_tdata[167:136];
            sb.check_answer(got);
        end
    end

    // offer one request; valid stays up after it for a back-to-back follower
    task automatic send_request(logic [1:0] op, logic [63:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= a;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_request(op, a);
        req_count++;
        @(negedge aclk);
    endtask

    // wait for all answers, let the block settle, then set capacity
    task automatic write_capacity(logic [6:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.clear_all(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // record burst of repeated pages then swap and resolve
    task automatic random_frame(int n);
        logic [63:0] pool [4];
        foreach (pool[i])
            pool[i] = {$urandom, $urandom};
        for (int i = 0; i < n; i++)
            send_request(OP_RECORD, ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                            : pool[$urandom_range(3)]);
        send_request(OP_SWAP, {$urandom, $urandom});
        send_request(OP_RESOLVE, {$urandom, $urandom});
    endtask

    task automatic random_phase(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(9))
                0: begin
                    send_request(OP_NONE, {$urandom, $urandom});
                end
                1: begin
                    send_request(OP_RESOLVE, '0);
                    sent++;
                end
                2: begin
                    send_request(OP_SWAP, '0);
                    sent++;
                end
                default: begin
                    n = $urandom_range(1, 10);
                    random_frame(n);
                    sent += n + 2;
                end
            endcase
        end
    endtask

    initial begin
        sb.clear_all(0);
        send_idle_pct = 37;
        recv_idle_pct = 87;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: capacity zero, empty resolves, unused opcode
        send_request(OP_RESOLVE, '0);
        send_request(OP_RECORD, '1);
        send_request(OP_SWAP, '0);
        send_request(OP_RESOLVE, '0);
        send_request(OP_NONE, '1);

        // small capacity: full bank, duplicates, repeated resolve
        write_capacity(7'd3);
        send_request(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_RECORD, 64'h0);
        send_request(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_RECORD, 64'h5555_AAAA_5555_AAAA);
        send_request(OP_SWAP, '0);
        send_request(OP_RESOLVE, '0);
        send_request(OP_RESOLVE, '0);
        send_request(OP_SWAP, '0);
        send_request(OP_RESOLVE, '0);

        // capacity above depth acts as depth; full 64 distinct entries
        write_capacity(7'd127);
        for (int i = 0; i < DEPTH + 1; i++)
            send_request(OP_RECORD, {$urandom, $urandom});
        send_request(OP_SWAP, '0);
        send_request(OP_RESOLVE, '0);

        // long receiver hold-off while records are offered and held back
        write_capacity(7'd64);
        hold_cycles = 300;
        for (int i = 0; i < 8; i++)
            send_request(OP_RECORD, 64'(i % 3));
        send_request(OP_SWAP, '0);
        send_request(OP_RESOLVE, '0);

        // random phases with changing idle patterns
        send_idle_pct = 37;
        recv_idle_pct = 87;
        write_capacity(7'd8);
        random_phase(10);
        send_idle_pct = 87;
        recv_idle_pct = 37;
        write_capacity(7'd1);
        random_phase(5);
        write_capacity(7'($urandom_range(2, 63)));
        random_phase(5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(7'd64);
        random_phase(10);

        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);

        $display("covered %0d requests and %0d results over capacities 0..127,",
                 req_count, sb.checked);
        $display("including drops, empty and repeated resolves and output stalls");
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
